/* sv/sauvola_local_threshold_unit_macros.svh */
// Assertion shorthands shared by the RTL files
`ifndef SAUVOLA_LOCAL_THRESHOLD_UNIT_MACROS_SVH
`define SAUVOLA_LOCAL_THRESHOLD_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define SAUV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define SAUV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/sauv_pkg.sv */
package sauv_pkg;

   // storage geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_WINDOW = 31;
   localparam int ROW_SLOTS  = 32;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int SLOT_W     = $clog2(ROW_SLOTS);
   localparam int ADDR_W     = COL_W + SLOT_W;

   // field and register widths
   localparam int PIX_W       = 8;
   localparam int IW_W        = 11;
   localparam int IH_W        = 12;
   localparam int WIN_W       = 5;
   localparam int K_W         = 8;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;

   // register reset values
   localparam logic [IW_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [IH_W-1:0]  IMAGE_HEIGHT_RST = 12'd480;
   localparam logic [WIN_W-1:0] WINDOW_SIZE_RST  = 5'd15;
   localparam logic [K_W-1:0]   K_COEFF_RST      = 8'd51;

   // input command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_WINDOW_SIZE,
      CSR_K_COEFF
   } csr_index_type;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_START,
      OP_SETUP,
      OP_WRITE,
      OP_CENTRE,
      OP_SCAN,
      OP_MUL1,
      OP_MUL2,
      OP_SQRT,
      OP_MUL3,
      OP_MUL4,
      OP_MUL5,
      OP_MUL6,
      OP_MUL7,
      OP_DSAT,
      OP_DIV,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic   capture;
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic active;
      logic complete;
      logic emit_due;
      logic scan_last;
      logic sqrt_done;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

/* sv/sauv_dpath.sv */
module sauv_dpath import sauv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [PIX_W-1:0]       req_pixel,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_foreground,
   output logic                   rsp_end_of_row,
   output logic                   rsp_end_of_frame
);

`include "sauvola_local_threshold_unit_macros.svh"

   localparam int RS_W = IH_W + 2;
   localparam int CS_W = IW_W + 1;

   // configuration and per-frame settings
   logic [IW_W-1:0]  cfg_width_ff;
   logic [IH_W-1:0]  cfg_height_ff;
   logic [WIN_W-1:0] cfg_window_ff;
   logic [K_W-1:0]   cfg_k_ff;
   logic [IW_W-1:0]  fr_w_ff;
   logic [IH_W-1:0]  fr_h_ff;
   logic [WIN_W-1:0] fr_win_ff;
   logic [K_W-1:0]   fr_k_ff;
   logic [14:0]      d_ff;
   logic [9:0]       n_ff;

   // frame position
   logic             active_ff;
   logic [COL_W-1:0] col_ff;
   logic [IH_W-1:0]  row_ff;
   logic [14:0]      pend_ff;
   logic [COL_W-1:0] out_col_ff;
   logic [IH_W-1:0]  out_row_ff;
   logic [PIX_W-1:0] pix_ff;

   // window scan and line store
   logic [WIN_W-1:0] scan_i_ff;
   logic [WIN_W-1:0] scan_j_ff;
   logic [PIX_W-1:0] mem [ROW_SLOTS*MAX_WIDTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic             rd_win_ff;
   logic             rd_ctr_ff;
   logic [17:0]      s_ff;
   logic [25:0]      q_ff;
   logic [PIX_W-1:0] centre_ff;

   // threshold arithmetic
   logic [35:0]      nq_ff;
   logic [35:0]      ss_ff;
   logic [19:0]      nn_ff;
   logic [18:0]      a_ff;
   logic [51:0]      sq_rem_ff;
   logic [51:0]      sq_res_ff;
   logic [51:0]      sq_bit_ff;
   logic [33:0]      ksq_ff;
   logic [34:0]      c_ff;
   logic [35:0]      plo_ff;
   logic [34:0]      phi_ff;
   logic [53:0]      num_ff;
   logic [53:0]      div_rem_ff;
   logic [53:0]      div_den_ff;
   logic [7:0]       quot_ff;
   logic             sat_ff;
   logic [2:0]       div_cnt_ff;

   // result register
   logic             rsp_valid_ff;
   logic             rsp_fg_ff;
   logic             rsp_eor_ff;
   logic             rsp_eof_ff;

   logic [3:0]       half;
   logic [RS_W-1:0]  row_s;
   logic [CS_W-1:0]  col_s;
   logic [IH_W-1:0]  row_cl;
   logic [COL_W-1:0] col_cl;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [IW_W-1:0]  fw;
   logic [IH_W-1:0]  fh;
   logic [WIN_W-1:0] ws;
   logic [35:0]      v;
   logic [51:0]      sq_sum;
   logic             div_ge;
   logic             eor_now;
   logic             eof_now;
   logic             scan_row_end;
   logic [8:0]       k_inv;

   assign half  = fr_win_ff[WIN_W-1:1];
   assign k_inv = 9'd256 - {1'b0, fr_k_ff};

   // clamped window coordinates, border replicated
   always_comb begin
      row_s = RS_W'(out_row_ff) + RS_W'(scan_i_ff) - RS_W'(half);
      if (row_s[RS_W-1]) begin
         row_cl = '0;
      end else if (row_s[RS_W-2:0] >= (RS_W-1)'(fr_h_ff)) begin
         row_cl = fr_h_ff - 12'd1;
      end else begin
         row_cl = row_s[IH_W-1:0];
      end
      col_s = CS_W'(out_col_ff) + CS_W'(scan_j_ff) - CS_W'(half);
      if (col_s[CS_W-1]) begin
         col_cl = '0;
      end else if (col_s[CS_W-2:0] >= fr_w_ff) begin
         col_cl = COL_W'(fr_w_ff - 11'd1);
      end else begin
         col_cl = col_s[COL_W-1:0];
      end
   end

   assign rd_addr = (cmd.op == OP_CENTRE) ? {out_row_ff[SLOT_W-1:0], out_col_ff}
                                          : {row_cl[SLOT_W-1:0], col_cl};
   assign wr_addr = {row_ff[SLOT_W-1:0], col_ff};

   // frame geometry taken from the registers at frame start
   always_comb begin
      fw = cfg_width_ff;
      if (fw < 11'd2) fw = 11'd2;
      if (fw > IW_W'(MAX_WIDTH)) fw = IW_W'(MAX_WIDTH);
      fh = cfg_height_ff;
      if (fh < 12'd2) fh = 12'd2;
      ws = cfg_window_ff;
      if (ws < 5'd3) ws = 5'd3;
      if (ws > WIN_W'(MAX_WINDOW)) ws = WIN_W'(MAX_WINDOW);
      if (!ws[0]) ws = ws - 5'd1;
      if (IW_W'(ws) > fw) ws = fw[WIN_W-1:0];
      if (IH_W'(ws) > fh) ws = fh[WIN_W-1:0];
      if (!ws[0]) ws = ws - 5'd1;
   end

   assign v       = nq_ff - ss_ff;
   assign sq_sum  = sq_res_ff + sq_bit_ff;
   assign div_ge  = div_rem_ff >= div_den_ff;
   assign eor_now = ({1'b0, out_col_ff} == (fr_w_ff - 11'd1));
   assign eof_now = eor_now && (out_row_ff == (fr_h_ff - 12'd1));
   assign scan_row_end = (scan_j_ff == (fr_win_ff - 5'd1));

   // line store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         mem[wr_addr] <= pix_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= IMAGE_WIDTH_RST;
         cfg_height_ff <= IMAGE_HEIGHT_RST;
         cfg_window_ff <= WINDOW_SIZE_RST;
         cfg_k_ff      <= K_COEFF_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_wdata[IW_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_wdata[IH_W-1:0];
            CSR_WINDOW_SIZE:  cfg_window_ff <= csr_wdata[WIN_W-1:0];
            CSR_K_COEFF:      cfg_k_ff      <= csr_wdata[K_W-1:0];
            default: ;
         endcase
      end
   end

   // frame control, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         d_ff         <= '0;
         fr_w_ff      <= 11'd2;
         fr_h_ff      <= 12'd2;
         fr_win_ff    <= 5'd1;
         fr_k_ff      <= '0;
         rd_win_ff    <= 1'b0;
         rd_ctr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_win_ff <= (cmd.op == OP_SCAN);
         rd_ctr_ff <= (cmd.op == OP_CENTRE);
         if (rsp_ready && (cmd.op != OP_EMIT)) rsp_valid_ff <= 1'b0;
         unique case (cmd.op)
            OP_START: begin
               fr_w_ff    <= fw;
               fr_h_ff    <= fh;
               fr_win_ff  <= ws;
               fr_k_ff    <= cfg_k_ff;
               active_ff  <= 1'b1;
               col_ff     <= '0;
               row_ff     <= '0;
               pend_ff    <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
            end
            OP_SETUP: d_ff <= 15'(half) * 15'(fr_w_ff) + 15'(half);
            OP_WRITE: begin
               pend_ff <= pend_ff + 15'd1;
               if ({1'b0, col_ff} == (fr_w_ff - 11'd1)) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 12'd1;
               end else begin
                  col_ff <= col_ff + COL_W'(1);
               end
            end
            OP_EMIT: begin
               rsp_valid_ff <= 1'b1;
               if (pend_ff != '0) pend_ff <= pend_ff - 15'd1;
               if (eof_now) begin
                  active_ff <= 1'b0;
               end else if (eor_now) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 12'd1;
               end else begin
                  out_col_ff <= out_col_ff + COL_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // arithmetic datapath
   always_ff @(posedge clock) begin
      if (cmd.capture) pix_ff <= req_pixel;
      if (rd_win_ff) begin
         s_ff <= s_ff + 18'(rd_data_ff);
         q_ff <= q_ff + 26'(16'(rd_data_ff) * 16'(rd_data_ff));
      end
      if (rd_ctr_ff) centre_ff <= rd_data_ff;
      unique case (cmd.op)
         OP_SETUP: n_ff <= 10'(fr_win_ff) * 10'(fr_win_ff);
         OP_CENTRE: begin
            scan_i_ff <= '0;
            scan_j_ff <= '0;
            s_ff      <= '0;
            q_ff      <= '0;
         end
         OP_SCAN: begin
            if (scan_row_end) begin
               scan_j_ff <= '0;
               scan_i_ff <= scan_i_ff + 5'd1;
            end else begin
               scan_j_ff <= scan_j_ff + 5'd1;
            end
         end
         OP_MUL1: begin
            nq_ff <= 36'(n_ff) * 36'(q_ff);
            ss_ff <= 36'(s_ff) * 36'(s_ff);
            nn_ff <= 20'(n_ff) * 20'(n_ff);
            a_ff  <= 19'(k_inv) * 19'(n_ff);
         end
         OP_MUL2: begin
            sq_rem_ff <= {v, 16'b0};
            sq_res_ff <= '0;
            sq_bit_ff <= 52'(1) << 50;
         end
         OP_SQRT: begin
            if (sq_rem_ff >= sq_sum) begin
               sq_rem_ff <= sq_rem_ff - sq_sum;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         OP_MUL3: ksq_ff <= 34'(fr_k_ff) * 34'(sq_res_ff[25:0]);
         OP_MUL4: c_ff <= 35'({a_ff, 15'b0}) + 35'(ksq_ff);
         OP_MUL5: begin
            plo_ff <= 36'(s_ff) * 36'(c_ff[17:0]);
            phi_ff <= 35'(s_ff) * 35'(c_ff[34:18]);
         end
         OP_MUL6: num_ff <= 54'(plo_ff) + 54'({phi_ff, 18'b0});
         OP_MUL7: div_rem_ff <= num_ff + 54'({nn_ff, 22'b0});
         OP_DSAT: begin
            sat_ff     <= div_rem_ff >= 54'({nn_ff, 31'b0});
            div_den_ff <= 54'({nn_ff, 30'b0});
            div_cnt_ff <= 3'd7;
            quot_ff    <= '0;
         end
         OP_DIV: begin
            if (div_ge) div_rem_ff <= div_rem_ff - div_den_ff;
            quot_ff    <= {quot_ff[6:0], div_ge};
            div_den_ff <= div_den_ff >> 1;
            div_cnt_ff <= div_cnt_ff - 3'd1;
         end
         OP_EMIT: begin
            rsp_fg_ff  <= !sat_ff && (centre_ff > quot_ff);
            rsp_eor_ff <= eor_now;
            rsp_eof_ff <= eof_now;
         end
         default: ;
      endcase
   end

   assign status.active    = active_ff;
   assign status.complete  = (row_ff == fr_h_ff);
   assign status.emit_due  = (pend_ff > d_ff);
   assign status.scan_last = scan_row_end && (scan_i_ff == (fr_win_ff - 5'd1));
   assign status.sqrt_done = (sq_bit_ff == '0);
   assign status.div_last  = (div_cnt_ff == 3'd0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_foreground   = rsp_fg_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

   `SAUV_ASSERT_SAME(a_pend_bound, clock, reset, active_ff, ({1'b0, pend_ff} <= ({1'b0, d_ff} + 16'd1)), "results lag the pixels by more than the window delay")
   `SAUV_ASSERT_NEXT(a_frame_close, clock, reset, (cmd.op == OP_EMIT) && eof_now, !active_ff, "frame still open after its last result")

endmodule

/* sv/sauv_ctrl.sv */
module sauv_ctrl import sauv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

`include "sauvola_local_threshold_unit_macros.svh"

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_SETUP,
      S_WRITE,
      S_CHECK,
      S_CENTRE,
      S_SCAN,
      S_DRAIN,
      S_MUL1,
      S_MUL2,
      S_SQRT,
      S_MUL3,
      S_MUL4,
      S_MUL5,
      S_MUL6,
      S_MUL7,
      S_DSAT,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and datapath operation
   always_comb begin
      state_in    = state_ff;
      cmd.capture = accept;
      cmd.op      = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!status.active && (req_command == CMD_PIXEL)) begin
                  state_in = S_START;
               end else if (!status.active) begin
                  state_in = S_IDLE;
               end else if (status.complete) begin
                  state_in = S_CENTRE;
               end else if (req_command == CMD_FLUSH) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_START: begin
            cmd.op   = OP_START;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.op   = OP_SETUP;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.op   = OP_WRITE;
            state_in = S_CHECK;
         end
         S_CHECK: state_in = status.emit_due ? S_CENTRE : S_IDLE;
         S_CENTRE: begin
            cmd.op   = OP_CENTRE;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (status.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_MUL1;
         S_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (status.sqrt_done) begin
               state_in = S_MUL3;
            end else begin
               cmd.op = OP_SQRT;
            end
         end
         S_MUL3: begin
            cmd.op   = OP_MUL3;
            state_in = S_MUL4;
         end
         S_MUL4: begin
            cmd.op   = OP_MUL4;
            state_in = S_MUL5;
         end
         S_MUL5: begin
            cmd.op   = OP_MUL5;
            state_in = S_MUL6;
         end
         S_MUL6: begin
            cmd.op   = OP_MUL6;
            state_in = S_MUL7;
         end
         S_MUL7: begin
            cmd.op   = OP_MUL7;
            state_in = S_DSAT;
         end
         S_DSAT: begin
            cmd.op   = OP_DSAT;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (status.div_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SAUV_ASSERT_SAME(a_emit_free, clock, reset, (cmd.op == OP_EMIT), status.out_free, "result loaded over one not yet taken")
   `SAUV_ASSERT_NEXT(a_idle_flush, clock, reset, accept && !status.active && (req_command == CMD_FLUSH), (state_ff == S_IDLE), "flush with no open frame started work")

endmodule

/* sv/sauvola_local_threshold_unit.sv */
// Sauvola local-threshold binariser for a raster stream of 8-bit gray pixels.
// req_ channel: one transfer per item; req_command selects a pixel or a flush
// tick, req_pixel carries the gray level. rsp_ channel: one transfer per
// result, foreground flag plus end-of-row and end-of-frame marks. csr_ channel:
// register writes (index 0 width, 1 height, 2 window size, 3 k), always ready;
// new values take effect at the first pixel of the next frame.
// Results follow the pixels in raster order, delayed by h rows plus h pixels
// (h = half the window); after the last pixel, one flush tick per remaining
// result drains the frame.
// A pixel is written to the line store and the pending count checked; a
// frame's first pixel latches the settings first. A result sums the window
// from the line store at one read per cycle, then a 26-step bit-serial square
// root and an 8-step restoring divide form the threshold.
// Reset clears the control state and restores register defaults; the line
// store needs no clearing pass. A finished result sits in the output register
// while the next item is taken in; if the receiver stalls, the following result
// waits for that register to empty.
module sauvola_local_threshold_unit import sauv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic [PIX_W-1:0]       req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_foreground,
   output logic                   rsp_end_of_row,
   output logic                   rsp_end_of_frame,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   // register writes never stall
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   sauv_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd)
   );

   sauv_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_pixel        (req_pixel),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_foreground   (rsp_foreground),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule
